// ----- design/bmpw_pkg.sv -----
`default_nettype none

package bmpw_pkg;

  // Input item kinds (tuser on the slave side)
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Header layout
  localparam int unsigned HDR_LEN  = 54;
  localparam logic [5:0]  HDR_LAST = 6'(HDR_LEN - 1);
  localparam logic [5:0]  PIX_LAST = 6'd2;

  // Field widths fixed by the stream format
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned COMP_W  = 17;
  localparam int unsigned HDIM_W  = 16;
  localparam int unsigned ROWB_W  = 18;

  typedef enum logic [0:0] {
    CMD_HEADER = 1'b0,
    CMD_PIXEL  = 1'b1
  } cmd_kind_e;

  // One command from the front to the back
  typedef struct packed {
    cmd_kind_e           kind;
    logic                frame_end;
    logic [1:0]          pad;
    logic [7:0]          byte_b;
    logic [7:0]          byte_g;
    logic [7:0]          byte_r;
    logic [HDIM_W-1:0]   width;
    logic [HDIM_W-1:0]   height;
    logic [ROWB_W-1:0]   row_bytes;
  } cmd_t;

  // Q1.16 intensity to byte: floor(min(v, 1.0) * 255)
  function automatic logic [7:0] to_byte(logic [COMP_W-1:0] v);
    logic [COMP_W-1:0] s;
    logic [24:0]       p;
    begin
      s = v[16] ? 17'h10000 : v;
      p = {s, 8'h00} - 25'(s);
      return p[23:16];
    end
  endfunction

  // Header byte at a given offset
  function automatic logic [7:0] hdr_byte(logic [5:0] idx, logic [HDIM_W-1:0] w,
                                          logic [HDIM_W-1:0] h, logic [31:0] size);
    logic [7:0] b;
    begin
      case (idx)
        6'd0:    b = 8'h42;
        6'd1:    b = 8'h4D;
        6'd2:    b = size[7:0];
        6'd3:    b = size[15:8];
        6'd4:    b = size[23:16];
        6'd5:    b = size[31:24];
        6'd10:   b = 8'd54;
        6'd14:   b = 8'd40;
        6'd18:   b = w[7:0];
        6'd19:   b = w[15:8];
        6'd22:   b = h[7:0];
        6'd23:   b = h[15:8];
        6'd26:   b = 8'd1;
        6'd28:   b = 8'd24;
        default: b = 8'h00;
      endcase
      return b;
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/bmp24_stream_writer.sv -----
// Channel     Direction  Handshake                     Payload
// s_axis      in         s_axis_tvalid_i/tready_o      tdata: red, green, blue; tuser: action
// m_axis      out        m_axis_tvalid_o/tready_i      tdata: byte; tlast: run end; tuser: file end
// cfg         in         cfg_valid_i/cfg_ready_o       cfg_addr_i, cfg_data_i
//
// A start item yields 54 header bytes, a pixel item 3 bytes plus 0..3 pad
// bytes at a row end; the output register sends one byte per cycle while
// the sink is ready. A two-entry command queue lets the input side take
// items while bytes drain. Reset clears position, frame and output state
// and sets both dimensions to 1. Config is always ready.
`default_nettype none

module bmp24_stream_writer #(
  parameter int unsigned MAX_DIM = 16384
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,  // red[16:0], green[33:17], blue[50:34], zeros
  input  wire logic        s_axis_tuser_i,  // action
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // out_byte
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o,  // file_end
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_addr_i,
  input  wire logic [14:0] cfg_data_i
);

  localparam int unsigned DimW = $clog2(MAX_DIM + 1);

  logic [bmpw_pkg::CFG_W-1:0] width_q, height_q;
  logic [DimW-1:0]            eff_w, eff_h;
  logic                       q_full, q_empty, push, pop;
  bmpw_pkg::cmd_t             push_cmd, pop_cmd;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 15'd1;
      height_q <= 15'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        bmpw_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        bmpw_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp dimensions to 1..MAX_DIM
  always_comb begin
    if (width_q == '0)
      eff_w = DimW'(1);
    else if (17'(width_q) > 17'(MAX_DIM))
      eff_w = DimW'(MAX_DIM);
    else
      eff_w = DimW'(width_q);
    if (height_q == '0)
      eff_h = DimW'(1);
    else if (17'(height_q) > 17'(MAX_DIM))
      eff_h = DimW'(MAX_DIM);
    else
      eff_h = DimW'(height_q);
  end

  bmpw_front #(.DimW(DimW)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .action_i   (s_axis_tuser_i),
    .red_i      (s_axis_tdata_i[16:0]),
    .green_i    (s_axis_tdata_i[33:17]),
    .blue_i     (s_axis_tdata_i[50:34]),
    .eff_w_i    (eff_w),
    .eff_h_i    (eff_h),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  bmpw_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (pop_cmd)
  );

  bmpw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o),
    .out_end_o   (m_axis_tuser_o)
  );

  // File end only on the last byte of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("file end without run end");

  // Queue never pushed without an accepted item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> s_axis_tvalid_i && s_axis_tready_o)
    else $error("command pushed without accepted item");

  // A start item is never dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tuser_i == bmpw_pkg::ACT_START |-> push)
    else $error("start item dropped");

  // Queue never popped while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- design/bmpw_fifo.sv -----
`default_nettype none

// Two-entry command queue between front and back
module bmpw_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire bmpw_pkg::cmd_t push_data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output bmpw_pkg::cmd_t     pop_data_o
);

  bmpw_pkg::cmd_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;

  assign full_o     = cnt_q[1];
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

// ----- design/bmpw_front.sv -----
`default_nettype none

// Accepts items, tracks row/column position and builds commands
module bmpw_front #(
  parameter int unsigned DimW = 15
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         action_i,
  input  wire logic [bmpw_pkg::COMP_W-1:0]  red_i,
  input  wire logic [bmpw_pkg::COMP_W-1:0]  green_i,
  input  wire logic [bmpw_pkg::COMP_W-1:0]  blue_i,
  input  wire logic [DimW-1:0]              eff_w_i,
  input  wire logic [DimW-1:0]              eff_h_i,
  input  wire logic                         q_full_i,
  output logic                              push_o,
  output bmpw_pkg::cmd_t                    cmd_o
);

  logic [DimW-1:0] col_q, col_d, row_q, row_d;
  logic            active_q, active_d;
  logic            accept, row_end, frame_end;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;

  assign row_end   = ((DimW+1)'(col_q) + 1'b1) >= (DimW+1)'(eff_w_i);
  assign frame_end = row_end & (((DimW+1)'(row_q) + 1'b1) >= (DimW+1)'(eff_h_i));

  // Classify: start always goes through, pixels only inside a frame
  assign push_o = accept & ((action_i == bmpw_pkg::ACT_START) | active_q);

  // Command build
  always_comb begin
    cmd_o           = '0;
    cmd_o.width     = bmpw_pkg::HDIM_W'(eff_w_i);
    cmd_o.height    = bmpw_pkg::HDIM_W'(eff_h_i);
    // row length in bytes: 3w plus pad, and pad equals w mod 4
    cmd_o.row_bytes = bmpw_pkg::ROWB_W'({eff_w_i, 1'b0}) + bmpw_pkg::ROWB_W'(eff_w_i)
                    + bmpw_pkg::ROWB_W'(eff_w_i[1:0]);
    if (action_i == bmpw_pkg::ACT_START) begin
      cmd_o.kind = bmpw_pkg::CMD_HEADER;
    end else begin
      cmd_o.kind      = bmpw_pkg::CMD_PIXEL;
      cmd_o.frame_end = frame_end;
      cmd_o.pad       = row_end ? eff_w_i[1:0] : 2'd0;
      cmd_o.byte_b    = bmpw_pkg::to_byte(blue_i);
      cmd_o.byte_g    = bmpw_pkg::to_byte(green_i);
      cmd_o.byte_r    = bmpw_pkg::to_byte(red_i);
    end
  end

  // Position update
  always_comb begin
    col_d    = col_q;
    row_d    = row_q;
    active_d = active_q;
    if (push_o) begin
      if (action_i == bmpw_pkg::ACT_START) begin
        col_d    = '0;
        row_d    = '0;
        active_d = 1'b1;
      end else if (row_end) begin
        col_d = '0;
        if (frame_end) begin
          row_d    = '0;
          active_d = 1'b0;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      active_q <= 1'b0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/bmpw_back.sv -----
`default_nettype none

// Turns commands into a byte stream, one byte per cycle while the output is ready
module bmpw_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           q_empty_i,
  input  wire bmpw_pkg::cmd_t q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                out_end_o
);

  bmpw_pkg::cmd_t cur_q;
  logic           busy_q, busy_d;
  logic [5:0]     idx_q, idx_d;
  logic [31:0]    size_q;
  logic [33:0]    prod;

  logic           ov_q, ov_d;
  logic [7:0]     ob_q, ob_d;
  logic           ol_q, ol_d, oe_q, oe_d;

  logic           advance, is_last;
  logic [5:0]     last_idx;
  logic [7:0]     cur_byte;

  assign advance  = ~ov_q | out_ready_i;
  assign last_idx = (cur_q.kind == bmpw_pkg::CMD_HEADER) ? bmpw_pkg::HDR_LAST
                  : bmpw_pkg::PIX_LAST + 6'(cur_q.pad);
  assign is_last  = (idx_q == last_idx);
  assign pop_o    = ~q_empty_i & (~busy_q | (advance & is_last));
  assign prod     = q_data_i.row_bytes * q_data_i.height;

  // Byte at the current offset
  always_comb begin
    if (cur_q.kind == bmpw_pkg::CMD_HEADER) begin
      cur_byte = bmpw_pkg::hdr_byte(idx_q, cur_q.width, cur_q.height, size_q);
    end else begin
      case (idx_q)
        6'd0:    cur_byte = cur_q.byte_b;
        6'd1:    cur_byte = cur_q.byte_g;
        6'd2:    cur_byte = cur_q.byte_r;
        default: cur_byte = 8'h00;
      endcase
    end
  end

  // Sequencing and output register
  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    ov_d   = ov_q;
    ob_d   = ob_q;
    ol_d   = ol_q;
    oe_d   = oe_q;
    if (advance) begin
      ov_d = busy_q;
      if (busy_q) begin
        ob_d  = cur_byte;
        ol_d  = is_last;
        oe_d  = is_last & (cur_q.kind == bmpw_pkg::CMD_PIXEL) & cur_q.frame_end;
        idx_d = idx_q + 6'd1;
        if (is_last) busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    ob_q <= ob_d;
    ol_q <= ol_d;
    oe_q <= oe_d;
    if (pop_o) begin
      cur_q  <= q_data_i;
      size_q <= prod[31:0] + 32'(bmpw_pkg::HDR_LEN);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      ov_q   <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = ob_q;
  assign out_last_o  = ol_q;
  assign out_end_o   = oe_q;

endmodule

`default_nettype wire

// ----- dv/bmp24_stream_writer_tb.sv -----
`timescale 1ns / 100ps

module bmp24_stream_writer_tb;

  localparam int unsigned MAX_DIM      = 16384;
  localparam int unsigned SETTLE_CYC   = 20;
  localparam int unsigned RANDOM_ITEMS = 140;
  localparam int unsigned TIMEOUT_NS   = 3_000_000;

  // One input item: start or pixel, with its color components
  typedef struct {
    logic        action;
    logic [16:0] red;
    logic [16:0] green;
    logic [16:0] blue;
    bit          hold;  // wait until every pending byte has arrived
  } bmp_item_t;

  // One output byte of the file stream
  typedef struct {
    logic [7:0] data;
    logic       run_last;
    logic       file_end;
  } bmp_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [55:0] s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [7:0]  m_data;
  logic        m_last;
  logic        m_user;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_addr = 1'b0;
  logic [14:0] cfg_data = '0;

  bmp_item_t pending_q[$];
  bmp_byte_t exp_bytes_q[$];
  bmp_item_t cur_item;

  // Shadow of the writer's registers and frame position
  logic [14:0] cfg_w = 15'd1;
  logic [14:0] cfg_h = 15'd1;
  int unsigned col_cnt = 0;
  int unsigned row_cnt = 0;
  bit          frame_open = 1'b0;

  bit          drained = 1'b1;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  int unsigned fail_cnt = 0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  int unsigned rx_cyc = 0;

  bmp24_stream_writer #(
    .MAX_DIM(MAX_DIM)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),   // red[16:0], green[33:17], blue[50:34], zeros
    .s_axis_tuser_i (s_user),   // action
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),   // out_byte
    .m_axis_tlast_o (m_last),
    .m_axis_tuser_o (m_user),   // file_end
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_addr_i     (cfg_addr),
    .cfg_data_i     (cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register value as the writer uses it: zero reads as one, clamp at MAX_DIM
  function automatic int unsigned clamp_dim(logic [14:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Q1.16 to 8 bits, saturating above 1.0
  function automatic logic [7:0] level_byte(logic [16:0] v);
    logic [31:0] s;
    s = (v > 17'h10000) ? 32'h10000 : 32'(v);
    return 8'((s * 32'd255) >> 16);
  endfunction

  function automatic logic [16:0] pick_level();
    case ($urandom_range(0, 7))
      0: return 17'h10000;
      1: return 17'h1FFFF;
      2: return 17'($urandom_range(0, 1)) ? 17'h0FFFF : 17'h00000;
      3: return 17'($urandom_range(17'h10001, 17'h1FFFF));
      default: return 17'($urandom_range(0, 17'h10000));
    endcase
  endfunction

  function automatic logic [14:0] pick_dim(int unsigned hi);
    case ($urandom_range(0, 19))
      0: return 15'd0;
      1: return 15'd16384;
      2: return 15'h7FFF;
      default: return 15'($urandom_range(1, hi));
    endcase
  endfunction

  task automatic push_byte(logic [7:0] d, logic last, logic fend);
    bmp_byte_t b;
    b.data = d;
    b.run_last = last;
    b.file_end = fend;
    exp_bytes_q.push_back(b);
  endtask

  // Expected bytes for one accepted item; advances the frame position
  task automatic predict_bytes(bmp_item_t it);
    int unsigned w, h, pad, n, i;
    logic [63:0] fsize;
    logic [31:0] w32, h32;
    logic [7:0]  hdr [54];
    logic [7:0]  px [3];
    bit          row_end, frame_end;
    w = clamp_dim(cfg_w);
    h = clamp_dim(cfg_h);
    pad = (4 - (w * 3) % 4) % 4;
    w32 = w;
    h32 = h;
    if (it.action == bmpw_pkg::ACT_START) begin
      fsize = 64'd54 + 64'd3 * w * h + 64'(pad) * h;
      for (i = 0; i < 54; i++) hdr[i] = 8'h00;
      hdr[0] = 8'h42;  // 'B'
      hdr[1] = 8'h4D;  // 'M'
      for (i = 0; i < 4; i++) begin
        hdr[2 + i]  = fsize[8*i +: 8];
        hdr[18 + i] = w32[8*i +: 8];
        hdr[22 + i] = h32[8*i +: 8];
      end
      hdr[10] = 8'd54;
      hdr[14] = 8'd40;
      hdr[26] = 8'd1;
      hdr[28] = 8'd24;
      for (i = 0; i < 54; i++) push_byte(hdr[i], i == 53, 1'b0);
      col_cnt = 0;
      row_cnt = 0;
      frame_open = 1'b1;
    end else if (frame_open) begin
      row_end = (col_cnt + 1 >= w);
      frame_end = row_end && (row_cnt + 1 >= h);
      n = 3 + (row_end ? pad : 0);
      // bytes go out blue, green, red, then row padding
      px[0] = level_byte(it.blue);
      px[1] = level_byte(it.green);
      px[2] = level_byte(it.red);
      for (i = 0; i < n; i++)
        push_byte((i < 3) ? px[i] : 8'h00, i == n - 1, frame_end && (i == n - 1));
      if (row_end) begin
        col_cnt = 0;
        if (frame_end) begin
          row_cnt = 0;
          frame_open = 1'b0;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
    end
  endtask

  task automatic add_item(logic act, logic [16:0] r, logic [16:0] g, logic [16:0] b,
                          bit hold);
    bmp_item_t it;
    it.action = act;
    it.red = r;
    it.green = g;
    it.blue = b;
    it.hold = hold;
    pending_q.push_back(it);
  endtask

  task automatic add_pixel(bit hold);
    add_item(bmpw_pkg::ACT_PIXEL, pick_level(), pick_level(), pick_level(), hold);
  endtask

  // Block until all items are sent and every byte is back, then let it settle
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_valid || exp_bytes_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr, logic [14:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= val;
    do @(posedge clk_i);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (addr == bmpw_pkg::REG_WIDTH) cfg_w = val;
    else cfg_h = val;
  endtask

  // Drain flag for the sender, sampled away from the active edge
  always @(negedge clk_i) drained <= (exp_bytes_q.size() == 0) && !s_valid;

  // Sender: bursts with random gaps, optional pause until drained
  always @(posedge clk_i) begin : driver
    if (rst_ni) begin
      if (s_valid && s_ready) predict_bytes(cur_item);
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_valid <= 1'b0;
        end else if (pending_q.size() != 0 && !(pending_q[0].hold && !drained)) begin
          cur_item = pending_q.pop_front();
          s_valid <= 1'b1;
          s_user  <= cur_item.action;
          s_data  <= {5'b0, cur_item.blue, cur_item.green, cur_item.red};
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: compare each byte, stall on a changing pattern
  always @(posedge clk_i) begin : monitor
    bmp_byte_t e;
    if (rst_ni) begin
      if (m_valid && m_ready) begin
        if (exp_bytes_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("ERROR: unexpected byte data=%02h last=%0b end=%0b",
                     m_data, m_last, m_user);
        end else begin
          e = exp_bytes_q.pop_front();
          if (m_data !== e.data || m_last !== e.run_last || m_user !== e.file_end) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("ERROR: exp data=%02h last=%0b end=%0b, got %02h %0b %0b",
                       e.data, e.run_last, e.file_end, m_data, m_last, m_user);
          end
        end
      end
      rx_cyc++;
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 4);
        rx_left = (rx_mode == 4) ? $urandom_range(1, 20) : $urandom_range(8, 80);
      end
      rx_left--;
      case (rx_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= 1'($urandom_range(0, 1));
        2: m_ready <= ($urandom_range(0, 3) == 0);
        3: m_ready <= (rx_cyc % 5 != 2);
        default: m_ready <= 1'b0;
      endcase
    end
  end

  initial begin : stimulus
    logic [14:0] w_reg, h_reg;
    int unsigned npix, kind, random_cnt, k;
    bit          closed;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset dimensions: stray pixel, 1x1 frame with one pad byte, stray pixel
    add_item(bmpw_pkg::ACT_PIXEL, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0);
    add_item(bmpw_pkg::ACT_START, 17'h0, 17'h0, 17'h0, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h10000, 17'h0FFFF, 17'h00001, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h0, 17'h0, 17'h0, 1'b0);
    wait_idle();

    // Zero dimensions read as one
    write_reg(bmpw_pkg::REG_WIDTH, 15'd0);
    write_reg(bmpw_pkg::REG_HEIGHT, 15'd0);
    add_item(bmpw_pkg::ACT_START, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h1FFFF, 17'h10001, 17'h000FF, 1'b0);
    wait_idle();

    // 3x2 with three pad bytes; restart in the middle of the frame
    write_reg(bmpw_pkg::REG_WIDTH, 15'd3);
    write_reg(bmpw_pkg::REG_HEIGHT, 15'd2);
    add_item(bmpw_pkg::ACT_START, 17'h0, 17'h0, 17'h0, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h00100, 17'h000FF, 17'h08000, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h0FFFF, 17'h10000, 17'h00000, 1'b0);
    add_item(bmpw_pkg::ACT_START, 17'h0, 17'h0, 17'h0, 1'b1);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h00000, 17'h00001, 17'h00101, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h0AAAA, 17'h15555, 17'h1FFFF, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h10000, 17'h10000, 17'h10000, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h0FF00, 17'h000FF, 17'h07FFF, 1'b1);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h18000, 17'h00080, 17'h0C000, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h00000, 17'h00000, 17'h00000, 1'b0);
    wait_idle();

    // Oversized dimensions clamp to the maximum; leave the frame open
    write_reg(bmpw_pkg::REG_WIDTH, 15'h7FFF);
    write_reg(bmpw_pkg::REG_HEIGHT, 15'd16384);
    add_item(bmpw_pkg::ACT_START, 17'h0, 17'h0, 17'h0, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h12345, 17'h0ABCD, 17'h00FFF, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h00010, 17'h1FFFF, 17'h0F0F0, 1'b0);
    wait_idle();

    // Narrow the row while the frame is open: the next pixel ends the row
    write_reg(bmpw_pkg::REG_WIDTH, 15'd2);
    write_reg(bmpw_pkg::REG_HEIGHT, 15'd16385);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h0, 17'h10000, 17'h0, 1'b0);
    add_item(bmpw_pkg::ACT_PIXEL, 17'h10000, 17'h0, 17'h10000, 1'b0);
    wait_idle();

    // Four pixels per row: no padding, frame ends on a pixel byte
    write_reg(bmpw_pkg::REG_WIDTH, 15'd4);
    write_reg(bmpw_pkg::REG_HEIGHT, 15'd1);
    add_item(bmpw_pkg::ACT_START, 17'h0, 17'h0, 17'h0, 1'b0);
    for (k = 0; k < 4; k++) add_pixel(1'b0);
    wait_idle();

    // Random frames under changing dimensions
    random_cnt = 0;
    while (random_cnt < RANDOM_ITEMS) begin
      w_reg = pick_dim(6);
      h_reg = pick_dim(3);
      write_reg(bmpw_pkg::REG_WIDTH, w_reg);
      write_reg(bmpw_pkg::REG_HEIGHT, h_reg);
      repeat ($urandom_range(2, 5)) begin
        add_item(bmpw_pkg::ACT_START, pick_level(), pick_level(), pick_level(),
                 $urandom_range(0, 5) == 0);
        random_cnt++;
        npix = clamp_dim(w_reg) * clamp_dim(h_reg);
        kind = $urandom_range(0, 9);
        closed = 1'b0;
        if (npix > 40) begin
          // never completes; the next start abandons it
          npix = $urandom_range(1, 12);
        end else if (kind == 0) begin
          npix = $urandom_range(0, npix - 1);
        end else begin
          closed = 1'b1;
        end
        for (k = 0; k < npix; k++) add_pixel($urandom_range(0, 31) == 0);
        random_cnt += npix;
        // stray pixels after a closed frame are dropped
        if (closed && kind == 1)
          repeat ($urandom_range(1, 3)) add_pixel(1'b0);
      end
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("bmp24_stream_writer verification clean");
    end else begin
      $display("bmp24_stream_writer verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("bmp24_stream_writer verification failed");
    $finish;
  end

endmodule
